// ===== rtl/core/snpad_pkg.sv =====
// shared types and constants for the snes pad multi-slot poller
package snpad_pkg;

  localparam int MAX_SLOTS     = 4;
  localparam int MAX_BITS      = 16;
  localparam int SLOTS_DEF     = 4;
  localparam int BITS_DEF      = 16;
  localparam int LANE_W        = 16;
  localparam int BYTE_W        = 8;
  localparam int IDX_W         = 4;
  localparam int BUTTONS_W     = MAX_SLOTS * LANE_W;

  typedef enum logic [2:0] {
    STG_LATCH   = 3'd0,
    STG_SAMPLE0 = 3'd1,
    STG_WAIT0   = 3'd2,
    STG_UNLATCH = 3'd3,
    STG_WAIT1   = 3'd4,
    STG_CLKHI   = 3'd5,
    STG_SAMPLE  = 3'd6,
    STG_IDLE    = 3'd7
  } stage_e;

  typedef struct packed {
    logic             start_req;
    logic [MAX_SLOTS-1:0] data_lines;
  } in_item_t;

  typedef struct packed {
    logic                 latch_out;
    logic                 clock_out;
    logic                 busy_res;
    logic                 done_res;
    logic [BUTTONS_W-1:0] buttons;
  } out_item_t;

  typedef struct packed {
    logic             clear;
    logic             sample;
    logic             done;
    logic [IDX_W-1:0] idx;
  } seq_ctl_t;

  typedef struct packed {
    logic latch;
    logic clock;
    logic busy;
  } line_t;

endpackage

// ===== rtl/core/snpad_seq.sv =====
// stage sequencer driving latch and clock and steering the lane samples
module snpad_seq #(
  parameter int BITS_PER_READ = snpad_pkg::BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic                start_req_i,
  output snpad_pkg::seq_ctl_t ctl_o,
  output snpad_pkg::line_t    lines_d_o
);

  localparam int IW = snpad_pkg::IDX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(BITS_PER_READ - 1);

  snpad_pkg::stage_e stage_q, stage_d;
  logic [IW-1:0]     idx_q, idx_d;
  logic              latch_q, latch_d;
  logic              clock_q, clock_d;
  logic              clear, sample, done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= snpad_pkg::STG_IDLE;
      idx_q   <= '0;
      latch_q <= 1'b0;
      clock_q <= 1'b0;
    end else if (advance_i) begin
      stage_q <= stage_d;
      idx_q   <= idx_d;
      latch_q <= latch_d;
      clock_q <= clock_d;
    end
  end

  always_comb begin
    stage_d = stage_q;
    idx_d   = idx_q;
    latch_d = latch_q;
    clock_d = clock_q;
    clear   = 1'b0;
    sample  = 1'b0;
    done    = 1'b0;
    unique case (stage_q)
      snpad_pkg::STG_IDLE: begin
        if (start_req_i) begin
          clear   = 1'b1;
          idx_d   = '0;
          latch_d = 1'b1;
          clock_d = 1'b0;
          stage_d = snpad_pkg::STG_SAMPLE0;
        end
      end
      snpad_pkg::STG_LATCH: begin
        latch_d = 1'b1;
        clock_d = 1'b0;
        stage_d = snpad_pkg::STG_SAMPLE0;
      end
      snpad_pkg::STG_SAMPLE0: begin
        sample  = 1'b1;
        stage_d = snpad_pkg::STG_WAIT0;
      end
      snpad_pkg::STG_WAIT0: begin
        stage_d = snpad_pkg::STG_UNLATCH;
      end
      snpad_pkg::STG_UNLATCH: begin
        latch_d = 1'b0;
        stage_d = snpad_pkg::STG_WAIT1;
      end
      snpad_pkg::STG_WAIT1: begin
        stage_d = snpad_pkg::STG_CLKHI;
      end
      snpad_pkg::STG_CLKHI: begin
        if (idx_q == LAST_IDX) begin
          done    = 1'b1;
          stage_d = snpad_pkg::STG_IDLE;
        end else begin
          clock_d = 1'b1;
          idx_d   = idx_q + IW'(1);
          stage_d = snpad_pkg::STG_SAMPLE;
        end
      end
      snpad_pkg::STG_SAMPLE: begin
        sample  = 1'b1;
        clock_d = 1'b0;
        stage_d = snpad_pkg::STG_CLKHI;
      end
      default: begin
        stage_d = snpad_pkg::STG_IDLE;
      end
    endcase
  end

  assign ctl_o.clear  = advance_i & clear;
  assign ctl_o.sample = advance_i & sample;
  assign ctl_o.done   = advance_i & done;
  assign ctl_o.idx    = idx_q;

  assign lines_d_o.latch = latch_d;
  assign lines_d_o.clock = clock_d;
  assign lines_d_o.busy  = (stage_d != snpad_pkg::STG_IDLE);

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.done |=> stage_q == snpad_pkg::STG_IDLE)
    else $error("poll end did not return to idle");

  a_clock_only_in_sample: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clock_q |-> stage_q == snpad_pkg::STG_SAMPLE)
    else $error("clock high outside sample stage");

  a_latch_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_q |-> (stage_q == snpad_pkg::STG_SAMPLE0 || stage_q == snpad_pkg::STG_WAIT0 ||
                 stage_q == snpad_pkg::STG_UNLATCH))
    else $error("latch high outside latch window");

endmodule

// ===== rtl/core/snpad_lane.sv =====
// one slot lane capturing the raw serial samples of its data line
module snpad_lane #(
  parameter int BITS_PER_READ = snpad_pkg::BITS_DEF
) (
  input  logic                     clk_i,
  input  snpad_pkg::seq_ctl_t      ctl_i,
  input  logic                     data_i,
  output logic [BITS_PER_READ-1:0] cap_o
);

  localparam int CIW = (BITS_PER_READ > 1) ? $clog2(BITS_PER_READ) : 1;

  logic [BITS_PER_READ-1:0] cap_q;
  logic [CIW-1:0]           pos;

  assign pos = ctl_i.idx[CIW-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.clear) begin
      cap_q <= '0;
    end else if (ctl_i.sample) begin
      cap_q[pos] <= cap_q[pos] | data_i;
    end
  end

  assign cap_o = cap_q;

endmodule

// ===== rtl/core/snpad_merge.sv =====
// merge stage packing the lane captures into the button word
module snpad_merge #(
  parameter int SLOTS         = snpad_pkg::SLOTS_DEF,
  parameter int BITS_PER_READ = snpad_pkg::BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  snpad_pkg::seq_ctl_t                       ctl_i,
  input  logic [SLOTS-1:0][BITS_PER_READ-1:0]       caps_i,
  output logic [snpad_pkg::BUTTONS_W-1:0]           buttons_d_o
);

  logic [snpad_pkg::BUTTONS_W-1:0] buttons_q, packed_w;

  always_comb begin
    packed_w = '0;
    for (int s = 0; s < SLOTS; s++) begin
      for (int i = 0; i < BITS_PER_READ; i++) begin
        packed_w[snpad_pkg::LANE_W * s + snpad_pkg::BYTE_W * (i >> 3) + 7 - (i & 7)] =
          ~caps_i[s][i];
      end
    end
  end

  assign buttons_d_o = ctl_i.done ? packed_w : buttons_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buttons_q <= '0;
    end else begin
      buttons_q <= buttons_d_o;
    end
  end

endmodule

// ===== rtl/core/snes_pad_multi_slot_poller.sv =====
// top level of the snes pad multi-slot poller with output skid buffer
//
//  port group   dir  beat           handshake
//  in_*         in   in_item_t      in_valid_i / in_stall_o
//  out_*        out  out_item_t     out_valid_o / out_stall_i
//
//  one tick beat in, one result beat out; a new beat every cycle while in_stall_o is low
//  result is registered into out_q once its tick beat is taken, or into the skid entry while the output stalls
//  reset puts the sequencer idle, lines low, button word zero
//  one skid entry holds a result while the output stalls
//  in_stall_o is high only while the skid entry is full
module snes_pad_multi_slot_poller #(
  parameter int SLOTS         = snpad_pkg::SLOTS_DEF,
  parameter int BITS_PER_READ = snpad_pkg::BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  snpad_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output snpad_pkg::out_item_t out_data_o
);

  snpad_pkg::seq_ctl_t              ctl;
  snpad_pkg::line_t                 lines_d;
  logic [SLOTS-1:0][BITS_PER_READ-1:0] caps;
  logic [snpad_pkg::BUTTONS_W-1:0]  buttons_d;
  snpad_pkg::out_item_t             res;
  snpad_pkg::out_item_t             out_q, skid_q;
  logic                             out_valid_q, skid_valid_q;
  logic                             in_fire, out_fire;

  assign in_fire  = in_valid_i & ~skid_valid_q;
  assign out_fire = out_valid_q & ~out_stall_i;

  snpad_seq #(
    .BITS_PER_READ(BITS_PER_READ)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (in_fire),
    .start_req_i(in_data_i.start_req),
    .ctl_o      (ctl),
    .lines_d_o  (lines_d)
  );

  for (genvar s = 0; s < SLOTS; s++) begin : g_lane
    snpad_lane #(
      .BITS_PER_READ(BITS_PER_READ)
    ) u_lane (
      .clk_i (clk_i),
      .ctl_i (ctl),
      .data_i(in_data_i.data_lines[s]),
      .cap_o (caps[s])
    );
  end

  snpad_merge #(
    .SLOTS        (SLOTS),
    .BITS_PER_READ(BITS_PER_READ)
  ) u_merge (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .caps_i     (caps),
    .buttons_d_o(buttons_d)
  );

  assign res.latch_out = lines_d.latch;
  assign res.clock_out = lines_d.clock;
  assign res.busy_res  = lines_d.busy;
  assign res.done_res  = ctl.done;
  assign res.buttons   = buttons_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry full while output empty");

endmodule

// ===== verif/snes_pad_multi_slot_poller_tb.sv =====
// self-checking testbench for the snes pad multi-slot poller with random idling and stalls
`timescale 1ns / 1ps

module snes_pad_multi_slot_poller_tb;

  localparam int SLOT_CNT  = 4;
  localparam int READ_BITS = 16;
  localparam logic [3:0] SLOT_MASK = 4'((1 << SLOT_CNT) - 1);
  localparam int TICK_CNT  = 2000;
  localparam int DIR_ROWS  = 24;
  localparam int HOLD_AT   = 300;
  localparam int HOLD_LEN  = 400;

  typedef struct packed {
    logic                 start;
    logic [3:0]           lines;
    logic                 typed;
    snpad_pkg::out_item_t want;
  } tick_row_t;

  localparam snpad_pkg::out_item_t IDLE_BEAT  = '0;
  localparam snpad_pkg::out_item_t LATCH_BEAT = '{latch_out: 1'b1, clock_out: 1'b0,
                                                  busy_res: 1'b1, done_res: 1'b0,
                                                  buttons: '0};
  localparam snpad_pkg::out_item_t BUSY_BEAT  = '{latch_out: 1'b0, clock_out: 1'b0,
                                                  busy_res: 1'b1, done_res: 1'b0,
                                                  buttons: '0};

  logic                 clk_i;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  snpad_pkg::in_item_t  in_beat   = '0;
  logic                 out_stall = 1'b0;
  logic                 in_stall_o;
  logic                 out_valid_o;
  snpad_pkg::out_item_t out_data_o;

  // poll sequencer mirror
  snpad_pkg::stage_e poll_stage = snpad_pkg::STG_IDLE;
  logic [4:0]        bit_pos    = '0;
  logic [3:0]        raw_samples [16] = '{default: '0};
  logic [63:0]       button_word = '0;
  logic              latch_lvl  = 1'b0;
  logic              clock_lvl  = 1'b0;

  snpad_pkg::out_item_t expected_beats [$];
  snpad_pkg::out_item_t want_beat;
  int                   fail_cnt     = 0;
  int                   beats_seen   = 0;
  bit                   hold_done    = 1'b0;
  int                   tx_calm      = 0;
  int                   rx_calm      = 0;
  tick_row_t            dir_rows [DIR_ROWS];

  snes_pad_multi_slot_poller i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall),
    .out_data_o (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;
  end

  initial begin
    #5_000_000;
    $display("snes_pad_multi_slot_poller verification failed");
    $finish;
  end

  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 60);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function logic [63:0] pack_buttons();
    logic [63:0] word;
    word = '0;
    for (int s = 0; s < SLOT_CNT; s++) begin
      for (int i = 0; i < READ_BITS; i++) begin
        if (!raw_samples[i][s]) begin
          word[16 * s + 8 * (i / 8) + 7 - (i % 8)] = 1'b1;
        end
      end
    end
    return word;
  endfunction

  function snpad_pkg::out_item_t predict_tick(input snpad_pkg::in_item_t it);
    snpad_pkg::out_item_t res;
    logic                 done;
    done = 1'b0;
    unique case (poll_stage)
      snpad_pkg::STG_IDLE: begin
        if (it.start_req) begin
          for (int k = 0; k < 16; k++) raw_samples[k] = '0;
          bit_pos    = '0;
          latch_lvl  = 1'b1;
          clock_lvl  = 1'b0;
          poll_stage = snpad_pkg::STG_SAMPLE0;
        end
      end
      snpad_pkg::STG_LATCH: begin
        latch_lvl  = 1'b1;
        clock_lvl  = 1'b0;
        poll_stage = snpad_pkg::STG_SAMPLE0;
      end
      snpad_pkg::STG_SAMPLE0: begin
        raw_samples[bit_pos[3:0]] |= it.data_lines & SLOT_MASK;
        poll_stage = snpad_pkg::STG_WAIT0;
      end
      snpad_pkg::STG_WAIT0: poll_stage = snpad_pkg::STG_UNLATCH;
      snpad_pkg::STG_UNLATCH: begin
        latch_lvl  = 1'b0;
        poll_stage = snpad_pkg::STG_WAIT1;
      end
      snpad_pkg::STG_WAIT1: poll_stage = snpad_pkg::STG_CLKHI;
      snpad_pkg::STG_CLKHI: begin
        if (int'(bit_pos) + 1 >= READ_BITS) begin
          button_word = pack_buttons();
          done        = 1'b1;
          poll_stage  = snpad_pkg::STG_IDLE;
        end else begin
          clock_lvl  = 1'b1;
          bit_pos    = bit_pos + 5'd1;
          poll_stage = snpad_pkg::STG_SAMPLE;
        end
      end
      snpad_pkg::STG_SAMPLE: begin
        raw_samples[bit_pos[3:0]] |= it.data_lines & SLOT_MASK;
        clock_lvl  = 1'b0;
        poll_stage = snpad_pkg::STG_CLKHI;
      end
      default: ;
    endcase
    res.latch_out = latch_lvl;
    res.clock_out = clock_lvl;
    res.busy_res  = (poll_stage != snpad_pkg::STG_IDLE);
    res.done_res  = done;
    res.buttons   = button_word;
    return res;
  endfunction

  task automatic send_tick(input snpad_pkg::in_item_t it, input logic typed,
                           input snpad_pkg::out_item_t want);
    int                   gap;
    snpad_pkg::out_item_t pred;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_beat  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = predict_tick(it);
    expected_beats.push_back(typed ? want : pred);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s expected %h got %h", $time, name, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && !out_stall) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        $display("%0t: beat with none expected, expected none got %h", $time, out_data_o);
        fail_cnt++;
      end else begin
        want_beat = expected_beats.pop_front();
        check_field("latch_out", 64'(want_beat.latch_out), 64'(out_data_o.latch_out));
        check_field("clock_out", 64'(want_beat.clock_out), 64'(out_data_o.clock_out));
        check_field("busy_res", 64'(want_beat.busy_res), 64'(out_data_o.busy_res));
        check_field("done_res", 64'(want_beat.done_res), 64'(out_data_o.done_res));
        check_field("buttons", want_beat.buttons, out_data_o.buttons);
      end
    end
  end

  initial begin
    int hold;
    wait (rst_n);
    forever begin
      if (!hold_done && beats_seen >= HOLD_AT) begin
        hold      = HOLD_LEN;
        hold_done = 1'b1;
      end else begin
        hold = draw_wait(rx_calm);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  initial begin
    snpad_pkg::in_item_t it;
    int                  lines_mode;
    logic [3:0]          fixed_lines;
    lines_mode  = 0;
    fixed_lines = '0;
    dir_rows = '{
      '{1'b0, 4'h0, 1'b1, IDLE_BEAT},
      '{1'b0, 4'hF, 1'b1, IDLE_BEAT},
      '{1'b1, 4'hF, 1'b1, LATCH_BEAT},
      '{1'b1, 4'h0, 1'b1, LATCH_BEAT},
      '{1'b0, 4'hF, 1'b1, LATCH_BEAT},
      '{1'b1, 4'h5, 1'b1, BUSY_BEAT},
      '{1'b0, 4'hA, 1'b1, BUSY_BEAT},
      '{1'b0, 4'h1, 1'b0, IDLE_BEAT},
      '{1'b1, 4'h8, 1'b0, IDLE_BEAT},
      '{1'b0, 4'h2, 1'b0, IDLE_BEAT},
      '{1'b0, 4'h4, 1'b0, IDLE_BEAT},
      '{1'b1, 4'hF, 1'b0, IDLE_BEAT},
      '{1'b0, 4'h0, 1'b0, IDLE_BEAT},
      '{1'b0, 4'h3, 1'b0, IDLE_BEAT},
      '{1'b0, 4'hC, 1'b0, IDLE_BEAT},
      '{1'b1, 4'h6, 1'b0, IDLE_BEAT},
      '{1'b0, 4'h9, 1'b0, IDLE_BEAT},
      '{1'b0, 4'h7, 1'b0, IDLE_BEAT},
      '{1'b0, 4'hE, 1'b0, IDLE_BEAT},
      '{1'b0, 4'hB, 1'b0, IDLE_BEAT},
      '{1'b0, 4'hD, 1'b0, IDLE_BEAT},
      '{1'b1, 4'hF, 1'b0, IDLE_BEAT},
      '{1'b0, 4'h0, 1'b0, IDLE_BEAT},
      '{1'b0, 4'hF, 1'b0, IDLE_BEAT}
    };
    wait (rst_n);
    @(posedge clk_i);
    for (int r = 0; r < DIR_ROWS; r++) begin
      it.start_req  = dir_rows[r].start;
      it.data_lines = dir_rows[r].lines;
      send_tick(it, dir_rows[r].typed, dir_rows[r].want);
    end
    for (int n = 0; n < TICK_CNT; n++) begin
      if (poll_stage == snpad_pkg::STG_IDLE) begin
        lines_mode   = $urandom_range(0, 4);
        fixed_lines  = 4'($urandom_range(0, 15));
        it.start_req = ($urandom_range(0, 3) != 0);
      end else begin
        it.start_req = 1'($urandom_range(0, 1));
      end
      unique case (lines_mode)
        1:       it.data_lines = 4'h0;
        2:       it.data_lines = 4'hF;
        3:       it.data_lines = fixed_lines;
        default: it.data_lines = 4'($urandom_range(0, 15));
      endcase
      send_tick(it, 1'b0, IDLE_BEAT);
    end
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("snes_pad_multi_slot_poller verification clean");
    end else begin
      $display("snes_pad_multi_slot_poller verification failed");
    end
    $finish;
  end

endmodule

// ===== snes_pad_multi_slot_poller.f =====
rtl/core/snpad_pkg.sv
rtl/core/snpad_seq.sv
rtl/core/snpad_lane.sv
rtl/core/snpad_merge.sv
rtl/core/snes_pad_multi_slot_poller.sv
verif/snes_pad_multi_slot_poller_tb.sv
